/* rtl/sbbct_pkg.sv */
// Shared types and constants for the swept box brush clip trace block.
`default_nettype none

package sbbct_pkg;

    localparam int CW         = 32;
    localparam int FRAC_BITS  = 16;
    localparam int QB         = FRAC_BITS + 8;
    localparam int FW         = QB + 1;
    localparam int DW         = 56;
    localparam int NRM_FRAC   = 14;
    localparam int MAX_PLANES = 128;
    localparam int PLANE_W    = $clog2(MAX_PLANES);
    localparam int BRUSH_W    = 16;
    localparam int QAW        = 2;
    localparam int QDEPTH     = 1 << QAW;
    localparam int QCW        = $clog2(QB);

    localparam logic signed [DW-1:0] DIST_EPS  = DW'(2048);
    localparam logic signed [FW-1:0] FRAC_ONE  = FW'(64'd1 << FRAC_BITS);
    localparam logic signed [FW-1:0] FRAC_MAX  = {1'b0, {QB{1'b1}}};
    localparam logic signed [FW-1:0] FRAC_MIN  = {1'b1, {QB{1'b0}}};
    localparam logic [FRAC_BITS:0]   OUT_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [2:0]           MUL_LAST  = 3'd6;

    typedef enum logic [1:0] {
        KIND_BEGIN = 2'd0,
        KIND_PLANE = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic signed [CW-1:0]  vx;
        logic signed [CW-1:0]  vy;
        logic signed [CW-1:0]  vz;
        logic signed [CW-1:0]  ex;
        logic signed [CW-1:0]  ey;
        logic signed [CW-1:0]  ez;
        logic signed [CW-1:0]  pdist;
        logic                  real_side;
        logic [BRUSH_W-1:0]    brush;
        logic                  last;
    } t_item;

    typedef struct packed {
        logic outside;
        logic miss;
    } t_flags;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_EVAL,
        ST_DIV,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

/* rtl/swept_box_brush_clip_trace.sv */
// Swept segment clip against plane-stream brushes: top level.
//
// Input channel: a transaction is taken when i_push is high and o_full low.
// Begin transactions load the segment and clear the running result, plane
// transactions feed one brush, end transactions produce one result.
// A four-entry queue sits between the accepting front end and the back end,
// so the host can keep pushing while the back end computes.
// A begin is taken from the idle state. A plane that does not cross the segment
// uses the one shared 32x32 multiplier; one that crosses it then also passes
// through the bit-serial dividers; and a plane whose brush is already known to
// miss skips both.
// An end transaction loads the result register when the idle back end takes it
// from the queue head; the result is shown while o_empty is low and leaves
// when i_pop is high. While a result waits, a further end transaction stays
// queued, and planes and begins behind it wait as well.
// Reset empties the queue and result register, clears the running trace state
// and sets the corner release enable to one. The configuration channel is
// always ready; the user writes it only while idle; the block does not check.
`default_nettype none

module swept_box_brush_clip_trace import sbbct_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    output logic                       o_full,
    input  wire logic [1:0]            i_kind,
    input  wire logic signed [CW-1:0]  i_vec_x,
    input  wire logic signed [CW-1:0]  i_vec_y,
    input  wire logic signed [CW-1:0]  i_vec_z,
    input  wire logic signed [CW-1:0]  i_end_x,
    input  wire logic signed [CW-1:0]  i_end_y,
    input  wire logic signed [CW-1:0]  i_end_z,
    input  wire logic signed [CW-1:0]  i_plane_dist,
    input  wire logic                  i_real_side,
    input  wire logic [BRUSH_W-1:0]    i_brush_index,
    input  wire logic                  i_last_plane,
    output logic                       o_empty,
    input  wire logic                  i_pop,
    output logic                       o_hit,
    output logic [FRAC_BITS:0]         o_fraction,
    output logic [BRUSH_W-1:0]         o_hit_brush,
    output logic [PLANE_W-1:0]         o_hit_plane,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic                  i_cfg_corner_release_enable
);

    logic   r_corner_en;
    t_item  head;
    logic   head_valid;
    logic   head_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner_en <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_corner_en <= i_cfg_corner_release_enable;
        end
    end

    sbbct_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_kind        (i_kind),
        .i_vec_x       (i_vec_x),
        .i_vec_y       (i_vec_y),
        .i_vec_z       (i_vec_z),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_end_z       (i_end_z),
        .i_plane_dist  (i_plane_dist),
        .i_real_side   (i_real_side),
        .i_brush_index (i_brush_index),
        .i_last_plane  (i_last_plane),
        .o_head        (head),
        .o_head_valid  (head_valid),
        .i_head_pop    (head_pop)
    );

    sbbct_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_corner_en  (r_corner_en),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_head_pop   (head_pop),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_hit        (o_hit),
        .o_fraction   (o_fraction),
        .o_hit_brush  (o_hit_brush),
        .o_hit_plane  (o_hit_plane)
    );

endmodule

`default_nettype wire

/* rtl/sbbct_front.sv */
// Front end: accepts transactions, drops unused kinds and queues the rest.
`default_nettype none

module sbbct_front import sbbct_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    output logic                       o_full,
    input  wire logic [1:0]            i_kind,
    input  wire logic signed [CW-1:0]  i_vec_x,
    input  wire logic signed [CW-1:0]  i_vec_y,
    input  wire logic signed [CW-1:0]  i_vec_z,
    input  wire logic signed [CW-1:0]  i_end_x,
    input  wire logic signed [CW-1:0]  i_end_y,
    input  wire logic signed [CW-1:0]  i_end_z,
    input  wire logic signed [CW-1:0]  i_plane_dist,
    input  wire logic                  i_real_side,
    input  wire logic [BRUSH_W-1:0]    i_brush_index,
    input  wire logic                  i_last_plane,
    output t_item                      o_head,
    output logic                       o_head_valid,
    input  wire logic                  i_head_pop
);

    t_item            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr;
    logic [QAW-1:0]   r_rd;
    logic [QAW:0]     r_cnt;
    logic             accept;
    logic             enq;
    logic             deq;
    t_item            item;

    assign o_full       = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];
    assign accept       = i_push && !o_full;
    // Kind three carries no command and is consumed here.
    assign enq = accept && ((i_kind == KIND_BEGIN) || (i_kind == KIND_PLANE) ||
                            (i_kind == KIND_END));
    assign deq = i_head_pop && o_head_valid;

    always_comb begin
        item.kind      = t_kind'(i_kind);
        item.vx        = i_vec_x;
        item.vy        = i_vec_y;
        item.vz        = i_vec_z;
        item.ex        = i_end_x;
        item.ey        = i_end_y;
        item.ez        = i_end_z;
        item.pdist     = i_plane_dist;
        item.real_side = i_real_side;
        item.brush     = i_brush_index;
        item.last      = i_last_plane;
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_mem[r_wr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (enq) begin
                r_wr <= r_wr + 1'b1;
            end
            if (deq) begin
                r_rd <= r_rd + 1'b1;
            end
            if (enq && !deq) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (deq && !enq) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/sbbct_div.sv */
// Restoring divider for saturating Q8.16 fractions, one quotient bit a cycle.
`default_nettype none

module sbbct_div import sbbct_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic signed [DW-1:0]  i_num,
    input  wire logic [DW-1:0]         i_den,
    output logic signed [FW-1:0]       o_quo,
    output logic                       o_done
);

    logic              r_busy;
    logic              r_done;
    logic [QCW-1:0]    r_cnt;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_den;
    logic [QB-1:0]     r_bits;
    logic [QB-1:0]     r_quo;
    logic              r_neg;
    logic              r_sat;
    logic [DW-1:0]     mag;
    logic [DW-1:0]     trial;
    logic              ge;
    logic signed [FW-1:0] quo_ext;

    assign mag   = i_num[DW-1] ? DW'(-i_num) : DW'(i_num);
    assign trial = {r_rem[DW-2:0], r_bits[QB-1]};
    assign ge    = (trial >= r_den);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_num[DW-1];
            // The quotient reaches 256 exactly when the magnitude reaches 256 * den.
            r_sat  <= ({8'd0, mag} >= {i_den, 8'd0});
            r_rem  <= mag >> 8;
            r_bits <= {mag[7:0], {FRAC_BITS{1'b0}}};
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= ge ? (trial - r_den) : trial;
            r_quo  <= {r_quo[QB-2:0], ge};
            r_bits <= r_bits << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == QCW'(QB - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign quo_ext = FW'(r_quo);
    assign o_done  = r_done;
    assign o_quo   = r_sat ? (r_neg ? FRAC_MIN : FRAC_MAX) : (r_neg ? -quo_ext : quo_ext);

endmodule

`default_nettype wire

/* rtl/sbbct_back.sv */
// Back end: distance products, plane fractions, brush decision and result register.
`default_nettype none

module sbbct_back import sbbct_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_corner_en,
    input  wire t_item                 i_head,
    input  wire logic                  i_head_valid,
    output logic                       o_head_pop,
    output logic                       o_empty,
    input  wire logic                  i_pop,
    output logic                       o_hit,
    output logic [FRAC_BITS:0]         o_fraction,
    output logic [BRUSH_W-1:0]         o_hit_brush,
    output logic [PLANE_W-1:0]         o_hit_plane
);

    t_state                 r_state, n_state;
    logic signed [CW-1:0]   r_start [3];
    logic signed [CW-1:0]   r_end [3];
    logic signed [CW-1:0]   r_nrm [3];
    logic                   r_real;
    logic                   r_last;
    logic [BRUSH_W-1:0]     r_brush;
    logic [2:0]             r_cnt;
    logic signed [63:0]     r_prod;
    logic signed [DW-1:0]   r_d0;
    logic signed [DW-1:0]   r_d1;
    logic                   r_leave_mode;

    logic [FRAC_BITS:0]     r_best_frac;
    logic [BRUSH_W-1:0]     r_best_brush;
    logic [PLANE_W-1:0]     r_best_plane;
    logic                   r_any_hit;

    logic signed [FW-1:0]   r_enter;
    logic signed [FW-1:0]   r_leave;
    logic signed [FW-1:0]   r_tenter;
    logic signed [FW-1:0]   r_tleave;
    logic                   r_enter_valid;
    logic [PLANE_W-1:0]     r_enter_plane;
    t_flags                 r_flags;
    logic [PLANE_W-1:0]     r_plane_cnt;

    logic                   r_out_valid;
    logic                   r_o_hit;
    logic [FRAC_BITS:0]     r_o_frac;
    logic [BRUSH_W-1:0]     r_o_brush;
    logic [PLANE_W-1:0]     r_o_plane;

    logic signed [CW-1:0]   sel_n;
    logic signed [CW-1:0]   sel_p;
    logic signed [63:0]     n_prod;
    logic signed [DW-1:0]   term;
    logic signed [DW-1:0]   pd_ext;
    logic                   d0_pos;
    logic                   d1_pos;
    logic signed [DW-1:0]   den_s;
    logic signed [DW-1:0]   num_a;
    logic signed [DW-1:0]   num_b;
    logic                   div_start;
    logic signed [FW-1:0]   q_a;
    logic signed [FW-1:0]   q_b;
    logic                   done_a;
    logic                   done_b;
    logic signed [FW-1:0]   enter_tt;
    logic signed [FW-1:0]   leave_tt;
    logic signed [FW-1:0]   best_ext;
    logic                   keep;
    logic                   win;

    always_comb begin
        case (r_cnt)
            3'd0: begin sel_n = r_nrm[0]; sel_p = r_start[0]; end
            3'd1: begin sel_n = r_nrm[1]; sel_p = r_start[1]; end
            3'd2: begin sel_n = r_nrm[2]; sel_p = r_start[2]; end
            3'd3: begin sel_n = r_nrm[0]; sel_p = r_end[0]; end
            3'd4: begin sel_n = r_nrm[1]; sel_p = r_end[1]; end
            default: begin sel_n = r_nrm[2]; sel_p = r_end[2]; end
        endcase
    end

    assign n_prod = sel_n * sel_p;
    // Arithmetic shift floors each product to Q16.16 before summing.
    assign term   = DW'(r_prod >>> NRM_FRAC);
    assign pd_ext = DW'($signed(i_head.pdist));

    assign d0_pos = (r_d0 > 0);
    assign d1_pos = (r_d1 > 0);
    assign den_s  = d0_pos ? (r_d0 - r_d1) : (r_d1 - r_d0);
    assign num_a  = d0_pos ? (r_d0 - DIST_EPS) : (-r_d0 - DIST_EPS);
    assign num_b  = d0_pos ? r_d0 : (DIST_EPS - r_d0);

    sbbct_div u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_a),
        .i_den   (den_s),
        .o_quo   (q_a),
        .o_done  (done_a)
    );

    sbbct_div u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_b),
        .i_den   (den_s),
        .o_quo   (q_b),
        .o_done  (done_b)
    );

    assign enter_tt = q_a[FW-1] ? '0 : q_a;
    assign leave_tt = (q_a > FRAC_ONE) ? FRAC_ONE : q_a;
    assign best_ext = FW'(r_best_frac);

    always_comb begin
        keep = !r_flags.miss && r_flags.outside && r_enter_valid && (r_enter < r_leave);
        if (i_corner_en && (r_tenter >= r_tleave)) begin
            keep = 1'b0;
        end
        win = keep && (r_enter < best_ext);
    end

    always_comb begin
        n_state    = r_state;
        o_head_pop = 1'b0;
        div_start  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head_valid) begin
                    unique case (i_head.kind)
                        KIND_BEGIN: o_head_pop = 1'b1;
                        KIND_PLANE: begin
                            o_head_pop = 1'b1;
                            n_state    = r_flags.miss ? ST_FIN : ST_MUL;
                        end
                        KIND_END: o_head_pop = !r_out_valid;
                        default: o_head_pop = 1'b1;
                    endcase
                end
            end
            ST_MUL: begin
                if (r_cnt == MUL_LAST) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                // A division is needed only when the segment crosses the plane.
                if (d0_pos != d1_pos) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_DIV: begin
                if (done_a && done_b) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_start[i] <= '0;
                r_end[i]   <= '0;
            end
            r_cnt         <= '0;
            r_best_frac   <= OUT_ONE;
            r_best_brush  <= '0;
            r_best_plane  <= '0;
            r_any_hit     <= 1'b0;
            r_enter       <= -FRAC_ONE;
            r_leave       <= FRAC_ONE;
            r_tenter      <= -FRAC_ONE;
            r_tleave      <= FRAC_MAX;
            r_enter_valid <= 1'b0;
            r_enter_plane <= '0;
            r_flags       <= '0;
            r_plane_cnt   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_head_pop) begin
                        case (i_head.kind)
                            KIND_BEGIN: begin
                                r_start[0]    <= i_head.vx;
                                r_start[1]    <= i_head.vy;
                                r_start[2]    <= i_head.vz;
                                r_end[0]      <= i_head.ex;
                                r_end[1]      <= i_head.ey;
                                r_end[2]      <= i_head.ez;
                                r_best_frac   <= OUT_ONE;
                                r_best_brush  <= '0;
                                r_best_plane  <= '0;
                                r_any_hit     <= 1'b0;
                                r_enter       <= -FRAC_ONE;
                                r_leave       <= FRAC_ONE;
                                r_tenter      <= -FRAC_ONE;
                                r_tleave      <= FRAC_MAX;
                                r_enter_valid <= 1'b0;
                                r_flags       <= '0;
                                r_plane_cnt   <= '0;
                            end
                            KIND_PLANE: begin
                                r_nrm[0] <= i_head.vx;
                                r_nrm[1] <= i_head.vy;
                                r_nrm[2] <= i_head.vz;
                                r_real   <= i_head.real_side;
                                r_last   <= i_head.last;
                                r_brush  <= i_head.brush;
                                r_d0     <= -pd_ext;
                                r_d1     <= -pd_ext;
                                r_cnt    <= '0;
                            end
                            KIND_END: begin
                                r_out_valid <= 1'b1;
                                r_o_hit     <= r_any_hit;
                                r_o_frac    <= r_best_frac;
                                r_o_brush   <= r_any_hit ? r_best_brush : '0;
                                r_o_plane   <= r_any_hit ? r_best_plane : '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MUL: begin
                    r_cnt  <= r_cnt + 1'b1;
                    r_prod <= n_prod;
                    if ((r_cnt >= 3'd1) && (r_cnt <= 3'd3)) begin
                        r_d0 <= r_d0 + term;
                    end else if (r_cnt >= 3'd4) begin
                        r_d1 <= r_d1 + term;
                    end
                end
                ST_EVAL: begin
                    r_leave_mode <= !d0_pos;
                    if (d0_pos) begin
                        r_flags.outside <= 1'b1;
                        if (d1_pos) begin
                            r_flags.miss <= 1'b1;
                        end
                    end
                end
                ST_DIV: begin
                    if (done_a && done_b) begin
                        if (!r_leave_mode) begin
                            if (enter_tt > r_enter) begin
                                r_enter       <= enter_tt;
                                r_enter_valid <= 1'b1;
                                r_enter_plane <= r_plane_cnt;
                            end
                            if (q_b > r_tenter) begin
                                r_tenter <= q_b;
                            end
                        end else begin
                            if (leave_tt < r_leave) begin
                                r_leave <= leave_tt;
                            end
                            if (r_real && (q_b < r_tleave)) begin
                                r_tleave <= q_b;
                            end
                        end
                    end
                end
                ST_FIN: begin
                    r_plane_cnt <= r_plane_cnt + 1'b1;
                    if (r_last) begin
                        if (win) begin
                            r_best_frac  <= r_enter[FRAC_BITS:0];
                            r_best_brush <= r_brush;
                            r_best_plane <= r_enter_plane;
                            r_any_hit    <= 1'b1;
                        end
                        r_enter       <= -FRAC_ONE;
                        r_leave       <= FRAC_ONE;
                        r_tenter      <= -FRAC_ONE;
                        r_tleave      <= FRAC_MAX;
                        r_enter_valid <= 1'b0;
                        r_flags       <= '0;
                        r_plane_cnt   <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_hit       = r_o_hit;
    assign o_fraction  = r_o_frac;
    assign o_hit_brush = r_o_brush;
    assign o_hit_plane = r_o_plane;

endmodule

`default_nettype wire

/* rtl/sbbct_check.sv */
// Port-level checker for the clip trace block, bound to the top level.
`default_nettype none

module sbbct_check import sbbct_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_full,
    input wire logic                o_empty,
    input wire logic                i_pop,
    input wire logic                o_hit,
    input wire logic [FRAC_BITS:0]  o_fraction,
    input wire logic [BRUSH_W-1:0]  o_hit_brush,
    input wire logic [PLANE_W-1:0]  o_hit_plane
);

    // A waiting result that is not taken stays on the ports.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_fraction) && $stable(o_hit)))
        else $error("waiting result changed");

    // Without a hit the result reads as the full segment with zero indexes.
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_hit) |->
            ((o_fraction == OUT_ONE) && (o_hit_brush == '0) && (o_hit_plane == '0)))
        else $error("miss result not clean");

    // A hit always lies before the end of the segment.
    a_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_hit) |-> (o_fraction < OUT_ONE))
        else $error("hit fraction out of range");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queues not empty after reset");

endmodule

bind swept_box_brush_clip_trace sbbct_check u_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_full      (o_full),
    .o_empty     (o_empty),
    .i_pop       (i_pop),
    .o_hit       (o_hit),
    .o_fraction  (o_fraction),
    .o_hit_brush (o_hit_brush),
    .o_hit_plane (o_hit_plane)
);

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for the swept box brush clip trace block.
`default_nettype none

module tb;
    import sbbct_pkg::*;

    localparam int  N_RANDOM  = 850;
    localparam longint LIMIT  = 3000000;
    localparam int  DRAIN     = 400;

    // Plain integer field layout of one trace transaction.
    typedef struct {
        logic [1:0]  kind;
        longint      vx, vy, vz, ex, ey, ez, pdist;
        bit          real_side;
        int unsigned brush;
        bit          last;
    } t_txn;

    typedef struct {
        bit          hit;
        int unsigned fraction;
        int unsigned brush;
        int unsigned plane;
    } t_hit;

    logic i_clk;
    logic i_rst_n;
    logic i_push;
    logic o_full;
    logic [1:0] i_kind;
    logic signed [CW-1:0] i_vec_x, i_vec_y, i_vec_z;
    logic signed [CW-1:0] i_end_x, i_end_y, i_end_z;
    logic signed [CW-1:0] i_plane_dist;
    logic i_real_side;
    logic [BRUSH_W-1:0] i_brush_index;
    logic i_last_plane;
    logic o_empty;
    logic i_pop;
    logic o_hit;
    logic [FRAC_BITS:0] o_fraction;
    logic [BRUSH_W-1:0] o_hit_brush;
    logic [PLANE_W-1:0] o_hit_plane;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic i_cfg_corner_release_enable;

    swept_box_brush_clip_trace uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_push), .o_full(o_full),
        .i_kind(i_kind),
        .i_vec_x(i_vec_x), .i_vec_y(i_vec_y), .i_vec_z(i_vec_z),
        .i_end_x(i_end_x), .i_end_y(i_end_y), .i_end_z(i_end_z),
        .i_plane_dist(i_plane_dist), .i_real_side(i_real_side),
        .i_brush_index(i_brush_index), .i_last_plane(i_last_plane),
        .o_empty(o_empty), .i_pop(i_pop),
        .o_hit(o_hit), .o_fraction(o_fraction),
        .o_hit_brush(o_hit_brush), .o_hit_plane(o_hit_plane),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_corner_release_enable(i_cfg_corner_release_enable)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Shadow copy of the clip state.
    bit          m_release;
    longint      m_start[3], m_end[3];
    longint      m_best;
    int unsigned m_best_brush, m_best_plane;
    bit          m_any;
    longint      m_enter, m_leave, m_tenter, m_tleave;
    int          m_enter_plane;
    bit          m_outside, m_miss;
    int unsigned m_count;

    t_hit   hit_queue[$];
    longint cycles;
    int     errors;
    int     mismatches;
    int     n_results;
    int     n_hits;
    int     send_idle;
    int     recv_idle;
    bit     check_next;
    t_hit   typed_hit;

    localparam longint F_ONE = 64'sd1 << FRAC_BITS;
    localparam longint F_MAX = (64'sd1 << QB) - 1;
    localparam longint F_MIN = -(64'sd1 << QB);
    localparam longint EPS   = 2048;

    function automatic longint floor14(longint p);
        if (p >= 0) return p >>> 14;
        return -(((-p) + 16383) >>> 14);
    endfunction

    function automatic longint plane_distance(longint n[3], longint pt[3], longint d);
        longint s;
        s = 0;
        for (int i = 0; i < 3; i++) s += floor14(n[i] * pt[i]);
        return s - d;
    endfunction

    function automatic longint crossing_frac(longint num, longint den);
        longint unsigned m, dd, q, r, f;
        m  = num < 0 ? longint'(-num) : longint'(num);
        dd = den;
        q  = m / dd;
        r  = m % dd;
        f  = q;
        if (q >= 256) return num < 0 ? F_MIN : F_MAX;
        for (int i = 0; i < FRAC_BITS; i++) begin
            r = r << 1;
            f = f << 1;
            if (r >= dd) begin
                r = r - dd;
                f = f | 1;
            end
        end
        return num < 0 ? -longint'(f) : longint'(f);
    endfunction

    task automatic brush_reset();
        m_enter = -F_ONE;
        m_leave = F_ONE;
        m_tenter = -F_ONE;
        m_tleave = F_MAX;
        m_enter_plane = -1;
        m_outside = 0;
        m_miss = 0;
        m_count = 0;
    endtask

    task automatic trace_reset();
        m_best = F_ONE;
        m_best_brush = 0;
        m_best_plane = 0;
        m_any = 0;
        brush_reset();
    endtask

    task automatic clip_plane(t_txn t);
        longint n[3], d0, d1, den, tt, tn;
        bit keep;
        n[0] = t.vx; n[1] = t.vy; n[2] = t.vz;
        if (!m_miss) begin
            d0 = plane_distance(n, m_start, t.pdist);
            d1 = plane_distance(n, m_end, t.pdist);
            if (d0 > 0) begin
                m_outside = 1;
                if (d1 > 0) begin
                    m_miss = 1;
                end else begin
                    den = d0 - d1;
                    tt = crossing_frac(d0 - EPS, den);
                    tn = crossing_frac(d0, den);
                    if (tt < 0) tt = 0;
                    if (tt > m_enter) begin
                        m_enter = tt;
                        m_enter_plane = m_count;
                    end
                    if (tn > m_tenter) m_tenter = tn;
                end
            end else if (d1 > 0) begin
                den = d1 - d0;
                tt = crossing_frac(-d0 - EPS, den);
                if (tt > F_ONE) tt = F_ONE;
                if (tt < m_leave) m_leave = tt;
                if (t.real_side) begin
                    tn = crossing_frac(EPS - d0, den);
                    if (tn < m_tleave) m_tleave = tn;
                end
            end
        end
        m_count = (m_count + 1) % MAX_PLANES;
        if (t.last) begin
            keep = !m_miss && m_outside && m_enter_plane >= 0 && m_enter < m_leave;
            if (keep && m_release && m_tenter >= m_tleave) keep = 0;
            if (keep && m_enter < m_best) begin
                m_best = m_enter;
                m_best_brush = t.brush & 16'hFFFF;
                m_best_plane = m_enter_plane;
                m_any = 1;
            end
            brush_reset();
        end
    endtask

    // Updates the shadow state and queues the hit report an end causes.
    task automatic predict_trace(t_txn t);
        t_hit h;
        case (t.kind)
            KIND_BEGIN: begin
                m_start[0] = t.vx; m_start[1] = t.vy; m_start[2] = t.vz;
                m_end[0] = t.ex; m_end[1] = t.ey; m_end[2] = t.ez;
                trace_reset();
            end
            KIND_PLANE: clip_plane(t);
            KIND_END: begin
                h.hit = m_any;
                h.fraction = 32'(m_best & 64'h1FFFF);
                h.brush = m_any ? m_best_brush : 0;
                h.plane = m_any ? (m_best_plane & 7'h7F) : 0;
                if (check_next && (typed_hit.hit != h.hit ||
                    typed_hit.fraction != h.fraction || typed_hit.brush != h.brush ||
                    typed_hit.plane != h.plane)) begin
                    errors++;
                    $display("directed row: typed %0d %0d %0d %0d, predicted %0d %0d %0d %0d",
                             typed_hit.hit, typed_hit.fraction, typed_hit.brush,
                             typed_hit.plane, h.hit, h.fraction, h.brush, h.plane);
                end
                check_next = 0;
                hit_queue = {hit_queue, h};
            end
            default: ;
        endcase
    endtask

    task automatic push_txn(t_txn t);
        while ($urandom_range(99) < send_idle) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_kind <= t.kind;
        i_vec_x <= t.vx[31:0]; i_vec_y <= t.vy[31:0]; i_vec_z <= t.vz[31:0];
        i_end_x <= t.ex[31:0]; i_end_y <= t.ey[31:0]; i_end_z <= t.ez[31:0];
        i_plane_dist <= t.pdist[31:0];
        i_real_side <= t.real_side;
        i_brush_index <= t.brush[15:0];
        i_last_plane <= t.last;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        predict_trace(t);
    endtask

    task automatic wait_idle();
        i_push <= 1'b0;
        while (hit_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_release(bit v);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_corner_release_enable <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        m_release = v;
    endtask

    function automatic t_txn make_txn(logic [1:0] k, longint a, longint b, longint c,
                                      longint d, bit rs, int unsigned br, bit l);
        t_txn t;
        t.kind = k;
        t.vx = a; t.vy = b; t.vz = c;
        t.ex = 0; t.ey = 0; t.ez = d;
        t.pdist = d;
        t.real_side = rs;
        t.brush = br;
        t.last = l;
        return t;
    endfunction

    function automatic longint s32(int unsigned v);
        return longint'($signed(v));
    endfunction

    function automatic t_txn rand_begin();
        t_txn t;
        t = make_txn(KIND_BEGIN, 0, 0, 0, 0, 0, 0, 0);
        if ($urandom_range(9) == 0) begin
            t.vx = s32($urandom); t.vy = s32($urandom); t.vz = s32($urandom);
            t.ex = s32($urandom); t.ey = s32($urandom); t.ez = s32($urandom);
        end else begin
            t.vx = $signed($urandom_range(0, 2 ** 22)) - 2 ** 21;
            t.vy = $signed($urandom_range(0, 2 ** 22)) - 2 ** 21;
            t.vz = $signed($urandom_range(0, 2 ** 22)) - 2 ** 21;
            t.ex = $signed($urandom_range(0, 2 ** 22)) - 2 ** 21;
            t.ey = $signed($urandom_range(0, 2 ** 22)) - 2 ** 21;
            t.ez = $signed($urandom_range(0, 2 ** 22)) - 2 ** 21;
        end
        return t;
    endfunction

    function automatic t_txn rand_plane(bit l, int unsigned br);
        t_txn t;
        int axis;
        t = make_txn(KIND_PLANE, 0, 0, 0, 0, 1'($urandom_range(1)), br, l);
        t.ez = s32($urandom);
        t.ex = s32($urandom);
        t.ey = s32($urandom);
        if ($urandom_range(9) == 0) begin
            t.vx = s32($urandom); t.vy = s32($urandom); t.vz = s32($urandom);
            t.pdist = s32($urandom);
        end else begin
            axis = $urandom_range(2);
            t.vx = axis == 0 ? ($urandom_range(1) ? 16384 : -16384)
                             : $signed($urandom_range(0, 8192)) - 4096;
            t.vy = axis == 1 ? ($urandom_range(1) ? 16384 : -16384)
                             : $signed($urandom_range(0, 8192)) - 4096;
            t.vz = axis == 2 ? ($urandom_range(1) ? 16384 : -16384)
                             : $signed($urandom_range(0, 8192)) - 4096;
            t.pdist = $signed($urandom_range(0, 2 ** 22)) - 2 ** 21;
        end
        return t;
    endfunction

    // Receiver: pops results and compares them with the oldest prediction.
    initial begin
        t_hit e;
        i_pop = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_pop && !o_empty && i_rst_n) begin
                if (hit_queue.size() == 0) begin
                    errors++;
                    if (mismatches++ < 10) $display("unexpected hit report");
                end else begin
                    e = hit_queue.pop_front();
                    n_results++;
                    if (e.hit) n_hits++;
                    if (o_hit !== e.hit || o_fraction !== e.fraction[16:0] ||
                        o_hit_brush !== e.brush[15:0] ||
                        o_hit_plane !== e.plane[6:0]) begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("mismatch: exp hit %0d frac %0d brush %0d plane %0d, got %0d %0d %0d %0d",
                                     e.hit, e.fraction, e.brush, e.plane,
                                     o_hit, o_fraction, o_hit_brush, o_hit_plane);
                    end
                end
            end
            i_pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    t_txn rows[$];
    t_hit row_hit[$];
    bit   row_typed[$];

    task automatic add_row(t_txn t, bit typed, t_hit h);
        rows = {rows, t};
        row_typed = {row_typed, typed};
        row_hit = {row_hit, h};
    endtask

    initial begin
        t_txn t;
        t_hit none;
        int nb;
        errors = 0; mismatches = 0; n_results = 0; n_hits = 0;
        check_next = 0;
        send_idle = 37; recv_idle = 88;
        i_rst_n = 1'b0; i_push = 1'b0; i_kind = KIND_BEGIN;
        i_vec_x = 0; i_vec_y = 0; i_vec_z = 0;
        i_end_x = 0; i_end_y = 0; i_end_z = 0; i_plane_dist = 0;
        i_real_side = 0; i_brush_index = 0; i_last_plane = 0;
        i_cfg_valid = 0; i_cfg_corner_release_enable = 0;
        for (int i = 0; i < 3; i++) begin
            m_start[i] = 0; m_end[i] = 0;
        end
        m_release = 1;
        trace_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        none = '{0, 65536, 0, 0};
        // End right after reset, and a repeated end.
        add_row(make_txn(KIND_END, 0, 0, 0, 0, 0, 0, 0), 1, none);
        add_row(make_txn(KIND_END, 0, 0, 0, 0, 0, 0, 0), 1, none);
        // Planes before any begin see a zero-length segment; unused kind.
        add_row(make_txn(KIND_PLANE, 16384, 0, 0, -65536, 1, 5, 1), 0, none);
        add_row(make_txn(2'd3, 0, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(make_txn(KIND_END, 0, 0, 0, 0, 0, 0, 0), 1, none);
        // Segment along x from -4 to +4 through a unit box.
        t = make_txn(KIND_BEGIN, -4 * 65536, 0, 0, 0, 0, 0, 0);
        t.ex = 4 * 65536;
        add_row(t, 0, none);
        add_row(make_txn(KIND_PLANE, -16384, 0, 0, 65536, 1, 7, 0), 0, none);
        add_row(make_txn(KIND_PLANE, 16384, 0, 0, 65536, 1, 7, 0), 0, none);
        add_row(make_txn(KIND_PLANE, 0, 16384, 0, 65536, 0, 7, 0), 0, none);
        add_row(make_txn(KIND_PLANE, 0, -16384, 0, 65536, 1, 7, 1), 0, none);
        add_row(make_txn(KIND_END, 0, 0, 0, 0, 0, 0, 0), 0, none);
        // A missing brush, a tie brush, then an open brush at the end.
        add_row(make_txn(KIND_PLANE, 0, 16384, 0, -65536, 1, 9, 0), 0, none);
        add_row(make_txn(KIND_PLANE, -16384, 0, 0, 65536, 1, 9, 1), 0, none);
        add_row(make_txn(KIND_PLANE, -16384, 0, 0, 65536, 1, 16'hFFFF, 0), 0, none);
        add_row(make_txn(KIND_PLANE, 16384, 0, 0, 65536, 1, 16'hFFFF, 1), 0, none);
        add_row(make_txn(KIND_PLANE, -16384, 0, 0, 32'sh7FFFFFFF, 1, 3, 0), 0, none);
        add_row(make_txn(KIND_END, 0, 0, 0, 0, 0, 0, 0), 0, none);
        // Extremes of every field, then a saturated crossing.
        t = make_txn(KIND_BEGIN, -64'sd2147483648, 64'sd2147483647, -64'sd2147483648,
                     0, 0, 0, 0);
        t.ex = 64'sd2147483647; t.ey = -64'sd2147483648; t.ez = 64'sd2147483647;
        add_row(t, 0, none);
        t = make_txn(KIND_PLANE, -64'sd2147483648, 64'sd2147483647, -64'sd2147483648,
                     -64'sd2147483648, 1, 16'hFFFF, 1);
        add_row(t, 0, none);
        add_row(make_txn(KIND_PLANE, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647,
                         64'sd2147483647, 0, 0, 1), 0, none);
        add_row(make_txn(KIND_END, 0, 0, 0, 0, 0, 0, 0), 0, none);

        for (int r = 0; r < rows.size(); r++) begin
            check_next = row_typed[r];
            typed_hit = row_hit[r];
            push_txn(rows[r]);
        end
        write_release(0);

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle = 88; recv_idle = 37;
                write_release(1);
            end
            if (phase == 2) begin
                send_idle = 0; recv_idle = 0;
                write_release(0);
            end
            for (int n = 0; n < N_RANDOM / 3; ) begin
                if ($urandom_range(9) == 0) begin
                    t = make_txn(2'($urandom_range(3)), s32($urandom), s32($urandom),
                                 s32($urandom), s32($urandom), 1'($urandom_range(1)),
                                 $urandom_range(16'hFFFF), 1'($urandom_range(1)));
                    push_txn(t);
                    n++;
                end else begin
                    push_txn(rand_begin());
                    n++;
                    nb = $urandom_range(1, 3);
                    for (int b = 0; b < nb; b++) begin
                        int np;
                        int unsigned br;
                        np = $urandom_range(1, 6);
                        br = $urandom_range(16'hFFFF);
                        for (int p = 0; p < np; p++) begin
                            push_txn(rand_plane(p == np - 1, br));
                            n++;
                        end
                    end
                    push_txn(make_txn(KIND_END, 0, 0, 0, 0, 0, 0, 0));
                    n++;
                end
            end
        end

        wait_idle();
        $display("Ran %0d end reports (%0d hits) over three idling phases,", n_results, n_hits);
        $display("with corner release switched on and off.");
        if (errors == 0 && hit_queue.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire
